[rtl/uts_pkg.sv]
// ----------------------------------------------------------------------------
// UTC timestamp validator package
// Shared constants, types and digit arithmetic for the timestamp checker.
// ----------------------------------------------------------------------------
package uts_pkg;

   localparam int unsigned TS_LEN    = 20;
   localparam int unsigned POS_W     = 5;
   localparam int unsigned YEAR_W    = 14;
   localparam int unsigned FIELD_W   = 7;
   localparam int unsigned CHAR_W    = 8;

   localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
   localparam logic [POS_W-1:0] POS_END    = 5'(TS_LEN);
   localparam logic [POS_W-1:0] POS_DASH_A = 5'd4;
   localparam logic [POS_W-1:0] POS_DASH_B = 5'd7;
   localparam logic [POS_W-1:0] POS_T      = 5'd10;
   localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
   localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
   localparam logic [POS_W-1:0] POS_Z      = 5'd19;

   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // Fields handed from the character scanner to the range checker.
   typedef struct packed {
      logic               fmt_ok;
      logic [FIELD_W-1:0] year_hi;
      logic [FIELD_W-1:0] year_lo;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } fin_type;

   // Checked result, fields already forced to zero when invalid.
   typedef struct packed {
      logic               valid_res;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } res_type;

   // acc * 10 + d, kept to the field width.
   function automatic logic [FIELD_W-1:0] push_digit(input logic [FIELD_W-1:0] acc,
                                                     input logic [3:0] d);
      logic [FIELD_W+3:0] sum;
      sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{FIELD_W{1'b0}}, d};
      return sum[FIELD_W-1:0];
   endfunction

endpackage

[rtl/uts_req_if.sv]
// ----------------------------------------------------------------------------
// Timestamp character channel
// One character of the string per word, with a flag on the final one.
// ----------------------------------------------------------------------------
interface uts_req_if;
   logic                       valid;
   logic                       ready;
   logic [uts_pkg::CHAR_W-1:0] ch;
   logic                       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

[rtl/uts_rsp_if.sv]
// ----------------------------------------------------------------------------
// Timestamp result channel
// One verdict word per string, with the decoded date and time fields.
// ----------------------------------------------------------------------------
interface uts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        valid_res;
   logic [uts_pkg::YEAR_W-1:0]  year;
   logic [uts_pkg::FIELD_W-1:0] month;
   logic [uts_pkg::FIELD_W-1:0] day;
   logic [uts_pkg::FIELD_W-1:0] hour;
   logic [uts_pkg::FIELD_W-1:0] minute;
   logic [uts_pkg::FIELD_W-1:0] second;

   modport source (output valid, output valid_res, output year, output month,
                   output day, output hour, output minute, output second,
                   input ready);
   modport sink   (input valid, input valid_res, input year, input month,
                   input day, input hour, input minute, input second,
                   output ready);
endinterface

[rtl/uts_scan.sv]
// ----------------------------------------------------------------------------
// Timestamp character scanner
// Checks each character against its position and accumulates digit fields.
// ----------------------------------------------------------------------------
module uts_scan (
   input  logic              clock,
   input  logic              reset,
   uts_req_if.sink           req_bus,
   input  logic              fin_take,
   output logic              fin_valid,
   output uts_pkg::fin_type  fin
);

   logic [uts_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        ferr_ff, ferr_in;
   logic [uts_pkg::FIELD_W-1:0] yhi_ff, yhi_in, ylo_ff, ylo_in;
   logic [uts_pkg::FIELD_W-1:0] mon_ff, mon_in, day_ff, day_in;
   logic [uts_pkg::FIELD_W-1:0] hour_ff, hour_in, min_ff, min_in;
   logic [uts_pkg::FIELD_W-1:0] sec_ff, sec_in;
   logic                        fin_valid_ff, fin_valid_in;
   uts_pkg::fin_type            fin_ff, fin_in;

   logic                        accept;
   logic                        is_digit;
   logic [3:0]                  digit;
   logic [uts_pkg::CHAR_W-1:0]  digit_full;

   assign req_bus.ready = !fin_valid_ff || fin_take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_digit      = (req_bus.ch >= uts_pkg::CHAR_ZERO) &&
                          (req_bus.ch <= uts_pkg::CHAR_NINE);
   assign digit_full    = req_bus.ch - uts_pkg::CHAR_ZERO;
   assign digit         = digit_full[3:0];

   // Updated scan state including the current character.
   always_comb begin
      pos_in  = (pos_ff == uts_pkg::POS_MAX) ? uts_pkg::POS_MAX : pos_ff + 5'd1;
      ferr_in = ferr_ff;
      yhi_in  = yhi_ff;
      ylo_in  = ylo_ff;
      mon_in  = mon_ff;
      day_in  = day_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      case (pos_ff) inside
         uts_pkg::POS_DASH_A, uts_pkg::POS_DASH_B: begin
            if (req_bus.ch != uts_pkg::CHAR_DASH) ferr_in = 1'b1;
         end
         uts_pkg::POS_T: begin
            if (req_bus.ch != uts_pkg::CHAR_T) ferr_in = 1'b1;
         end
         uts_pkg::POS_COLON_A, uts_pkg::POS_COLON_B: begin
            if (req_bus.ch != uts_pkg::CHAR_COLON) ferr_in = 1'b1;
         end
         uts_pkg::POS_Z: begin
            if (req_bus.ch != uts_pkg::CHAR_Z) ferr_in = 1'b1;
         end
         [5'd0:5'd18]: begin
            if (!is_digit) begin
               ferr_in = 1'b1;
            end else begin
               case (pos_ff) inside
                  [5'd0:5'd1]:   yhi_in  = uts_pkg::push_digit(yhi_ff, digit);
                  [5'd2:5'd3]:   ylo_in  = uts_pkg::push_digit(ylo_ff, digit);
                  [5'd5:5'd6]:   mon_in  = uts_pkg::push_digit(mon_ff, digit);
                  [5'd8:5'd9]:   day_in  = uts_pkg::push_digit(day_ff, digit);
                  [5'd11:5'd12]: hour_in = uts_pkg::push_digit(hour_ff, digit);
                  [5'd14:5'd15]: min_in  = uts_pkg::push_digit(min_ff, digit);
                  default:       sec_in  = uts_pkg::push_digit(sec_ff, digit);
               endcase
            end
         end
         default: ferr_in = 1'b1;
      endcase
   end

   always_comb begin
      fin_in.fmt_ok  = !ferr_in && (pos_in == uts_pkg::POS_END);
      fin_in.year_hi = yhi_in;
      fin_in.year_lo = ylo_in;
      fin_in.month   = mon_in;
      fin_in.day     = day_in;
      fin_in.hour    = hour_in;
      fin_in.minute  = min_in;
      fin_in.second  = sec_in;
      if (accept && req_bus.last) begin
         fin_valid_in = 1'b1;
      end else if (fin_take) begin
         fin_valid_in = 1'b0;
      end else begin
         fin_valid_in = fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ferr_ff      <= 1'b0;
         yhi_ff       <= '0;
         ylo_ff       <= '0;
         mon_ff       <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (accept) begin
            if (req_bus.last) begin
               // The string is complete: start afresh for the next one.
               pos_ff  <= '0;
               ferr_ff <= 1'b0;
               yhi_ff  <= '0;
               ylo_ff  <= '0;
               mon_ff  <= '0;
               day_ff  <= '0;
               hour_ff <= '0;
               min_ff  <= '0;
               sec_ff  <= '0;
            end else begin
               pos_ff  <= pos_in;
               ferr_ff <= ferr_in;
               yhi_ff  <= yhi_in;
               ylo_ff  <= ylo_in;
               mon_ff  <= mon_in;
               day_ff  <= day_in;
               hour_ff <= hour_in;
               min_ff  <= min_in;
               sec_ff  <= sec_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.last) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

[rtl/uts_range.sv]
// ----------------------------------------------------------------------------
// Timestamp range checker
// Checks the decoded fields against calendar and clock limits.
// ----------------------------------------------------------------------------
module uts_range (
   input  uts_pkg::fin_type fin,
   output uts_pkg::res_type res
);

   logic                        leap;
   logic [uts_pkg::FIELD_W-1:0] mdays;
   logic                        ok;
   logic [uts_pkg::YEAR_W-1:0]  year;

   // The year is hundreds times year_hi plus year_lo, so divisibility by
   // four depends on year_lo alone, and by 400 on year_hi when year_lo is zero.
   assign leap = (fin.year_lo == '0) ? (fin.year_hi[1:0] == 2'b00)
                                     : (fin.year_lo[1:0] == 2'b00);

   assign year = uts_pkg::YEAR_W'(fin.year_hi) * 14'd100 + uts_pkg::YEAR_W'(fin.year_lo);

   always_comb begin
      case (fin.month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mdays = 7'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                    mdays = 7'd30;
         7'd2:                                       mdays = leap ? 7'd29 : 7'd28;
         default:                                    mdays = 7'd0;
      endcase
   end

   assign ok = fin.fmt_ok &&
               (fin.month >= 7'd1) && (fin.month <= 7'd12) &&
               (fin.day >= 7'd1) && (fin.day <= mdays) &&
               (fin.hour <= 7'd23) && (fin.minute <= 7'd59) && (fin.second <= 7'd59);

   always_comb begin
      res.valid_res = ok;
      res.year      = ok ? year       : '0;
      res.month     = ok ? fin.month  : '0;
      res.day       = ok ? fin.day    : '0;
      res.hour      = ok ? fin.hour   : '0;
      res.minute    = ok ? fin.minute : '0;
      res.second    = ok ? fin.second : '0;
   end

endmodule

[rtl/utc_timestamp_validator_top.sv]
// ----------------------------------------------------------------------------
// UTC timestamp validator
// Validates YYYY-MM-DDTHH:MM:SSZ strings fed one character per word.
// ----------------------------------------------------------------------------
// One character is taken every cycle while the result side keeps up. Each
// character updates the position count and field accumulators as it is
// accepted; the word flagged last also loads a register with the completed
// fields, whose ranges are checked on the way into the output register.
// Fields read zero whenever the verdict is invalid.
module utc_timestamp_validator_top (
   input  logic     clock,
   input  logic     reset,
   uts_req_if.sink  req_bus,
   uts_rsp_if.source rsp_bus
);

   logic             fin_valid;
   logic             fin_take;
   logic             out_free;
   uts_pkg::fin_type fin;
   uts_pkg::res_type res;

   logic             rsp_valid_ff, rsp_valid_in;
   uts_pkg::res_type rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fin_take = fin_valid && out_free;

   uts_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .fin_take  (fin_take),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   uts_range u_range (
      .fin (fin),
      .res (res)
   );

   assign rsp_valid_in = out_free ? fin_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.valid_res = rsp_ff.valid_res;
   assign rsp_bus.year      = rsp_ff.year;
   assign rsp_bus.month     = rsp_ff.month;
   assign rsp_bus.day       = rsp_ff.day;
   assign rsp_bus.hour      = rsp_ff.hour;
   assign rsp_bus.minute    = rsp_ff.minute;
   assign rsp_bus.second    = rsp_ff.second;

   // A flagged last character always leaves a completed string pending.
   a_last_fills: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.last |=> fin_valid)
      else $error("last character did not produce a pending result");

   // An invalid verdict carries all-zero fields.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.valid_res |->
         rsp_bus.year == '0 && rsp_bus.month == '0 && rsp_bus.day == '0 &&
         rsp_bus.hour == '0 && rsp_bus.minute == '0 && rsp_bus.second == '0)
      else $error("invalid result with non-zero fields");

   // A valid verdict lies within calendar and clock limits.
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.valid_res |->
         rsp_bus.month >= 7'd1 && rsp_bus.month <= 7'd12 && rsp_bus.day >= 7'd1 &&
         rsp_bus.day <= 7'd31 && rsp_bus.hour <= 7'd23 && rsp_bus.minute <= 7'd59 &&
         rsp_bus.second <= 7'd59 && rsp_bus.year <= 14'd9999)
      else $error("valid result out of range");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC timestamp validator testbench
// Feeds timestamp strings one character per word, some well formed and some
// broken, with random gaps on both channels and one long hold-off on the
// verdict side. Every verdict word is compared with a local model.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned TARGET_CHARS = 1150;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned LIMIT_CYCLES = 1000000;

   // Tracks the character scanner and keeps the verdicts still to come.
   class verdict_board;
      logic [uts_pkg::POS_W-1:0]   pos;
      logic                        fmt_err;
      logic [uts_pkg::YEAR_W-1:0]  yr;
      logic [uts_pkg::FIELD_W-1:0] mo, dy, hr, mn, sc;
      uts_pkg::res_type            pending_verdicts[$];
      int unsigned                 mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         pos     = '0;
         fmt_err = 1'b0;
         yr      = '0;
         mo      = '0;
         dy      = '0;
         hr      = '0;
         mn      = '0;
         sc      = '0;
      endfunction

      function int unsigned month_len(int unsigned y, int unsigned m);
         bit leap;
         leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function void note_char(logic [uts_pkg::CHAR_W-1:0] c, logic fin);
         logic [uts_pkg::POS_W-1:0] idx;
         logic [3:0]                d;
         bit                        ok;
         uts_pkg::res_type          want;
         idx = pos;
         if (idx >= uts_pkg::POS_END) begin
            fmt_err = 1'b1;
         end else if (idx == uts_pkg::POS_DASH_A || idx == uts_pkg::POS_DASH_B) begin
            if (c != uts_pkg::CHAR_DASH) fmt_err = 1'b1;
         end else if (idx == uts_pkg::POS_T) begin
            if (c != uts_pkg::CHAR_T) fmt_err = 1'b1;
         end else if (idx == uts_pkg::POS_COLON_A || idx == uts_pkg::POS_COLON_B) begin
            if (c != uts_pkg::CHAR_COLON) fmt_err = 1'b1;
         end else if (idx == uts_pkg::POS_Z) begin
            if (c != uts_pkg::CHAR_Z) fmt_err = 1'b1;
         end else if (c < uts_pkg::CHAR_ZERO || c > uts_pkg::CHAR_NINE) begin
            // The field accumulator keeps its value on a bad digit.
            fmt_err = 1'b1;
         end else begin
            d = 4'(c - uts_pkg::CHAR_ZERO);
            if (idx < uts_pkg::POS_DASH_A)       yr = uts_pkg::YEAR_W'(yr * 10 + d);
            else if (idx < uts_pkg::POS_DASH_B)  mo = uts_pkg::FIELD_W'(mo * 10 + d);
            else if (idx < uts_pkg::POS_T)       dy = uts_pkg::FIELD_W'(dy * 10 + d);
            else if (idx < uts_pkg::POS_COLON_A) hr = uts_pkg::FIELD_W'(hr * 10 + d);
            else if (idx < uts_pkg::POS_COLON_B) mn = uts_pkg::FIELD_W'(mn * 10 + d);
            else                                 sc = uts_pkg::FIELD_W'(sc * 10 + d);
         end
         pos = (idx == uts_pkg::POS_MAX) ? uts_pkg::POS_MAX : idx + 1'b1;

         if (fin) begin
            ok = !fmt_err && pos == uts_pkg::POS_END;
            if (ok && (mo < 1 || mo > 12)) ok = 0;
            if (ok && (dy < 1 || dy > month_len(yr, mo))) ok = 0;
            if (ok && (hr > 23 || mn > 59 || sc > 59)) ok = 0;
            want = '0;
            if (ok) begin
               want.valid_res = 1'b1;
               want.year      = yr;
               want.month     = mo;
               want.day       = dy;
               want.hour      = hr;
               want.minute    = mn;
               want.second    = sc;
            end
            pending_verdicts.push_back(want);
            clear();
         end
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_verdict(uts_pkg::res_type got);
         uts_pkg::res_type want;
         if (pending_verdicts.size() == 0) begin
            $error("verdict word arrived with none outstanding");
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare("valid_res", want.valid_res, got.valid_res);
         compare("year", want.year, got.year);
         compare("month", want.month, got.month);
         compare("day", want.day, got.day);
         compare("hour", want.hour, got.hour);
         compare("minute", want.minute, got.minute);
         compare("second", want.second, got.second);
      endfunction

      function int unsigned outstanding();
         return pending_verdicts.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   int unsigned chars_sent = 0;
   int unsigned cycles = 0;
   verdict_board sb;
   uts_pkg::res_type seen_verdict;
   logic [uts_pkg::CHAR_W-1:0] text_q[$];

   uts_req_if req_bus();
   uts_rsp_if rsp_bus();

   utc_timestamp_validator_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_verdict.valid_res = rsp_bus.valid_res;
         seen_verdict.year      = rsp_bus.year;
         seen_verdict.month     = rsp_bus.month;
         seen_verdict.day       = rsp_bus.day;
         seen_verdict.hour      = rsp_bus.hour;
         seen_verdict.minute    = rsp_bus.minute;
         seen_verdict.second    = rsp_bus.second;
         sb.check_verdict(seen_verdict);
      end
   end

   // Most pauses are short; now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 30);
   endfunction

   function automatic void add_num(int unsigned v, int unsigned n);
      int unsigned div;
      div = 1;
      repeat (n - 1) div *= 10;
      repeat (n) begin
         text_q.push_back(uts_pkg::CHAR_ZERO + uts_pkg::CHAR_W'(v / div % 10));
         div /= 10;
      end
   endfunction

   function automatic void add_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
      text_q.delete();
      add_num(y, 4);
      text_q.push_back(uts_pkg::CHAR_DASH);
      add_num(mo, 2);
      text_q.push_back(uts_pkg::CHAR_DASH);
      add_num(d, 2);
      text_q.push_back(uts_pkg::CHAR_T);
      add_num(h, 2);
      text_q.push_back(uts_pkg::CHAR_COLON);
      add_num(mi, 2);
      text_q.push_back(uts_pkg::CHAR_COLON);
      add_num(s, 2);
      text_q.push_back(uts_pkg::CHAR_Z);
   endfunction

   function automatic void cut_to(int unsigned len);
      while (text_q.size() > len) void'(text_q.pop_back());
   endfunction

   task automatic send_char(input logic [uts_pkg::CHAR_W-1:0] c, input logic fin);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch    <= c;
      req_bus.last  <= fin;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_char(c, fin);
      chars_sent++;
   endtask

   task automatic send_text();
      int unsigned n;
      n = text_q.size();
      for (int unsigned i = 0; i < n; i++) send_char(text_q[i], i == n - 1);
   endtask

   // Verdict side: random back-pressure, plus one long hold-off part way
   // through so that the block backs up into its character input.
   initial begin : rsp_pacing
      int unsigned run, stall, r;
      bit          held;
      held = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && chars_sent >= 300) begin
            held = 1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         run = (r < 20) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 20)      stall = 0;
         else if (r < 75) stall = $urandom_range(1, 3);
         else if (r < 95) stall = $urandom_range(4, 12);
         else             stall = $urandom_range(20, 40);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : main
      int unsigned y, mo, dy, hr, mn, sc, kind, n;
      sb = new();
      req_bus.valid <= 1'b0;
      req_bus.ch    <= '0;
      req_bus.last  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Leap years, calendar extremes and each range limit.
      add_stamp(2024, 2, 29, 23, 59, 59); send_text();
      add_stamp(2023, 2, 29, 0, 0, 0);    send_text();
      add_stamp(1900, 2, 29, 1, 2, 3);    send_text();
      add_stamp(2000, 2, 29, 12, 30, 45); send_text();
      add_stamp(0, 1, 1, 0, 0, 0);        send_text();
      add_stamp(9999, 12, 31, 23, 59, 59); send_text();
      add_stamp(9999, 99, 99, 99, 99, 99); send_text();
      add_stamp(2021, 0, 10, 5, 5, 5);    send_text();
      add_stamp(2021, 13, 10, 5, 5, 5);   send_text();
      add_stamp(2021, 4, 31, 5, 5, 5);    send_text();
      add_stamp(2021, 5, 0, 5, 5, 5);     send_text();
      add_stamp(2021, 5, 9, 24, 5, 5);    send_text();
      add_stamp(2021, 5, 9, 5, 60, 5);    send_text();
      add_stamp(2021, 5, 9, 5, 5, 60);    send_text();
      // Lower-case terminator, then a non-digit with the top bit set.
      add_stamp(2022, 6, 15, 10, 20, 30);
      text_q[uts_pkg::POS_Z] = uts_pkg::CHAR_Z + 8'h20;
      send_text();
      add_stamp(2022, 6, 15, 10, 20, 30); text_q[2] = 8'hFF; send_text();
      // Strings that end early, one just too long and one that saturates.
      add_stamp(2022, 6, 15, 10, 20, 30); cut_to(8);  send_text();
      add_stamp(2022, 6, 15, 10, 20, 30); cut_to(19); send_text();
      add_stamp(2022, 6, 15, 10, 20, 30); text_q.push_back(uts_pkg::CHAR_Z); send_text();
      add_stamp(2022, 6, 15, 10, 20, 30);
      repeat (25) text_q.push_back(uts_pkg::CHAR_ZERO + 8'd7);
      send_text();
      text_q.delete(); text_q.push_back(uts_pkg::CHAR_ZERO + 8'd1); send_text();

      while (chars_sent < TARGET_CHARS) begin
         y  = ($urandom_range(0, 99) < 15) ? 100 * $urandom_range(0, 99)
                                           : $urandom_range(0, 9999);
         mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
         dy = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
         if ($urandom_range(0, 19) == 0) dy = $urandom_range(0, 99);
         hr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
         mn = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         sc = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         add_stamp(y, mo, dy, hr, mn, sc);
         kind = $urandom_range(0, 99);
         if (kind >= 94) begin
            // Pure noise of random length, 1 to 40 characters, and any content.
            text_q.delete();
            n = $urandom_range(1, 40);
            repeat (n) text_q.push_back(uts_pkg::CHAR_W'($urandom_range(0, 255)));
         end else if (kind >= 88) begin
            n = $urandom_range(1, 15);
            repeat (n) text_q.push_back(($urandom_range(0, 1) == 1)
                        ? uts_pkg::CHAR_ZERO + uts_pkg::CHAR_W'($urandom_range(0, 9))
                        : uts_pkg::CHAR_W'($urandom_range(0, 255)));
         end else if (kind >= 80) begin
            cut_to($urandom_range(1, 19));
         end else if (kind >= 70) begin
            text_q[$urandom_range(0, 19)] = uts_pkg::CHAR_W'($urandom_range(0, 255));
         end
         send_text();
      end
      req_bus.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
